/* rtl/lsc_pkg.sv */
// Shared widths, constants and types of the level-set curvature pipeline.
package lsc_pkg;

    localparam int PHI_W      = 16;
    localparam int COORD_W    = 12;
    localparam int PHI_FRAC   = 8;
    localparam int GRID_W     = 13;
    localparam int KAPPA_W    = 32;
    localparam int CFG_IDX_W  = 2;

    // Alignment of a Q(PHI_FRAC) numerator to a Q16 quotient.
    localparam int NORM_SHIFT = 15 - PHI_FRAC;

    // First differences, second differences and cross term.
    localparam int D1_W   = PHI_W + 1;
    localparam int D2_W   = PHI_W + 2;
    localparam int SQ_W   = 2 * D1_W;
    localparam int DEN_W  = SQ_W;
    localparam int TERM_W = SQ_W + D2_W + 1;
    localparam int NUM_W  = TERM_W + 2;

    // Divider operands: dividend 2*|num|*2^NORM_SHIFT + den, divisor 2*den.
    localparam int NN_W   = NUM_W + NORM_SHIFT + 2;
    localparam int DD_W   = DEN_W + 1;
    localparam int CMP_W  = (NN_W > DD_W + KAPPA_W) ? NN_W : DD_W + KAPPA_W;

    // Width for the border tests on row and column.
    localparam int BND_W  = (COORD_W + 1 > GRID_W) ? COORD_W + 1 : GRID_W;

    localparam int IN_TDATA_W  = ((2 * COORD_W + 9 * PHI_W + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((2 * COORD_W + KAPPA_W + 7) / 8) * 8;
    localparam int PHI_LSB     = 2 * COORD_W;
    localparam int KAPPA_LSB   = 2 * COORD_W;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;
    localparam t_cfg_idx CFG_GRID_ROWS = t_cfg_idx'(0);
    localparam t_cfg_idx CFG_GRID_COLS = t_cfg_idx'(1);

    localparam logic [GRID_W-1:0] GRID_RESET = GRID_W'(256);

    localparam logic [KAPPA_W-1:0] KAPPA_MIN = KAPPA_W'(1) << (KAPPA_W - 1);
    localparam logic [KAPPA_W-1:0] KAPPA_MAX = ~KAPPA_MIN;

    typedef logic signed [PHI_W-1:0] t_phi;

    typedef struct packed {
        logic [GRID_W-1:0] rows;
        logic [GRID_W-1:0] cols;
    } t_grid_cfg;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        t_phi               phi_center;
        t_phi               phi_up;
        t_phi               phi_down;
        t_phi               phi_left;
        t_phi               phi_right;
        t_phi               phi_up_left;
        t_phi               phi_down_right;
        t_phi               phi_down_left;
        t_phi               phi_up_right;
    } t_point;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               dz;
        logic               neg;
        logic [NN_W-1:0]    nn;
        logic [DD_W-1:0]    dd;
    } t_div_in;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic [KAPPA_W-1:0] kappa;
    } t_result;

endpackage

/* rtl/lsc_num.sv */
// Five-stage front end: differences, products, terms, numerator and divider operands.
module lsc_num (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  lsc_pkg::t_grid_cfg i_grid,
    input  logic              i_valid,
    output logic              o_ready,
    input  lsc_pkg::t_point   i_point,
    output logic              o_valid,
    input  logic              i_ready,
    output lsc_pkg::t_div_in  o_div
);
    import lsc_pkg::*;

    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic en1, en2, en3, en4, en5;

    // Stage 1 registers
    logic [COORD_W-1:0]     r1_row, r1_col;
    logic signed [D1_W-1:0] r1_a, r1_b;
    logic signed [D2_W-1:0] r1_xx, r1_yy, r1_z;
    logic signed [D1_W-1:0] n1_a, n1_b;
    logic signed [D2_W-1:0] n1_xx, n1_yy, n1_z;

    // Stage 2 registers
    logic [COORD_W-1:0]     r2_row, r2_col;
    logic signed [SQ_W-1:0] r2_aa, r2_bb, r2_ab;
    logic signed [D2_W-1:0] r2_xx, r2_yy, r2_z;

    // Stage 3 registers
    logic [COORD_W-1:0]       r3_row, r3_col;
    logic signed [TERM_W-1:0] r3_t1, r3_t2, r3_t3;
    logic [DEN_W-1:0]         r3_den;

    // Stage 4 registers
    logic [COORD_W-1:0]      r4_row, r4_col;
    logic signed [NUM_W-1:0] r4_num;
    logic [DEN_W-1:0]        r4_den;

    // Stage 5 register
    t_div_in r5;
    t_div_in n5;

    t_phi p_c, p_up, p_dn, p_lf, p_rt, p_ul, p_dr, p_dl, p_ur;
    logic [BND_W-1:0] row_p1, col_p1;
    logic xok, yok;
    logic signed [D2_W:0] xx2, yy2;
    logic [NUM_W-1:0] mag;

    // A stage moves on when it is empty or its successor moves on.
    assign en5     = !r_v5 || i_ready;
    assign en4     = !r_v4 || en5;
    assign en3     = !r_v3 || en4;
    assign en2     = !r_v2 || en3;
    assign en1     = !r_v1 || en2;
    assign o_ready = en1;
    assign o_valid = r_v5;
    assign o_div   = r5;

    always_comb begin
        p_c  = i_point.phi_center;
        p_up = i_point.phi_up;
        p_dn = i_point.phi_down;
        p_lf = i_point.phi_left;
        p_rt = i_point.phi_right;
        p_ul = i_point.phi_up_left;
        p_dr = i_point.phi_down_right;
        p_dl = i_point.phi_down_left;
        p_ur = i_point.phi_up_right;

        row_p1 = BND_W'(i_point.row) + BND_W'(1);
        col_p1 = BND_W'(i_point.col) + BND_W'(1);
        xok    = (i_point.row != '0) && (row_p1 < BND_W'(i_grid.rows));
        yok    = (i_point.col != '0) && (col_p1 < BND_W'(i_grid.cols));

        n1_a  = '0;
        n1_xx = '0;
        n1_b  = '0;
        n1_yy = '0;
        n1_z  = '0;
        if (xok) begin
            n1_a  = D1_W'(p_up) - D1_W'(p_dn);
            n1_xx = D2_W'(p_up) + D2_W'(p_dn) - (D2_W'(p_c) <<< 1);
        end
        if (yok) begin
            n1_b  = D1_W'(p_lf) - D1_W'(p_rt);
            n1_yy = D2_W'(p_lf) + D2_W'(p_rt) - (D2_W'(p_c) <<< 1);
        end
        if (xok && yok) begin
            n1_z = D2_W'(p_ul) + D2_W'(p_dr) - D2_W'(p_dl) - D2_W'(p_ur);
        end
    end

    assign xx2 = $signed({r2_xx, 1'b0});
    assign yy2 = $signed({r2_yy, 1'b0});

    always_comb begin
        mag = r4_num[NUM_W-1] ? $unsigned(-r4_num) : $unsigned(r4_num);
        n5.row = r4_row;
        n5.col = r4_col;
        n5.neg = r4_num[NUM_W-1];
        n5.dz  = (r4_den == '0);
        n5.nn  = (NN_W'(mag) << (NORM_SHIFT + 1)) + NN_W'(r4_den);
        n5.dd  = {r4_den, 1'b0};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
            if (en5) r_v5 <= r_v4;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r1_row <= i_point.row;
            r1_col <= i_point.col;
            r1_a   <= n1_a;
            r1_b   <= n1_b;
            r1_xx  <= n1_xx;
            r1_yy  <= n1_yy;
            r1_z   <= n1_z;
        end
        if (en2) begin
            r2_row <= r1_row;
            r2_col <= r1_col;
            r2_aa  <= SQ_W'(r1_a) * SQ_W'(r1_a);
            r2_bb  <= SQ_W'(r1_b) * SQ_W'(r1_b);
            r2_ab  <= SQ_W'(r1_a) * SQ_W'(r1_b);
            r2_xx  <= r1_xx;
            r2_yy  <= r1_yy;
            r2_z   <= r1_z;
        end
        if (en3) begin
            r3_row <= r2_row;
            r3_col <= r2_col;
            r3_t1  <= TERM_W'(xx2) * TERM_W'(r2_bb);
            r3_t2  <= TERM_W'(yy2) * TERM_W'(r2_aa);
            r3_t3  <= TERM_W'(r2_ab) * TERM_W'(r2_z);
            r3_den <= $unsigned(r2_aa) + $unsigned(r2_bb);
        end
        if (en4) begin
            r4_row <= r3_row;
            r4_col <= r3_col;
            r4_num <= NUM_W'(r3_t1) + NUM_W'(r3_t2) - NUM_W'(r3_t3);
            r4_den <= r3_den;
        end
        if (en5) begin
            r5 <= n5;
        end
    end

endmodule

/* rtl/lsc_div.sv */
// Pipelined restoring divider with round-to-nearest and Q16.16 saturation.
module lsc_div (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  lsc_pkg::t_div_in i_div,
    output logic             o_valid,
    input  logic             i_ready,
    output lsc_pkg::t_result o_res
);
    import lsc_pkg::*;

    // Overflow check, one stage per quotient bit, then the result register.
    localparam int NST = KAPPA_W + 2;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               dz;
        logic               neg;
        logic               ovf;
        logic [NN_W-1:0]    rem;
        logic [DD_W-1:0]    dd;
        logic [KAPPA_W-1:0] q;
    } t_div_st;

    logic [NST-1:0] r_v;
    logic [NST-1:0] en;
    t_div_st        r_st [0:KAPPA_W];
    t_div_st        n_st0;
    t_result        r_res;
    t_result        n_res;

    assign en[NST-1] = !r_v[NST-1] || i_ready;
    for (genvar k = 0; k < NST - 1; k++) begin : g_en
        assign en[k] = !r_v[k] || en[k+1];
    end

    assign o_ready = en[0];
    assign o_valid = r_v[NST-1];
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (en[0]) r_v[0] <= i_valid;
            for (int k = 1; k < NST; k++) begin
                if (en[k]) r_v[k] <= r_v[k-1];
            end
        end
    end

    // A quotient of 2^KAPPA_W or more saturates in either direction.
    always_comb begin
        n_st0.row = i_div.row;
        n_st0.col = i_div.col;
        n_st0.dz  = i_div.dz;
        n_st0.neg = i_div.neg;
        n_st0.ovf = CMP_W'(i_div.nn) >= (CMP_W'(i_div.dd) << KAPPA_W);
        n_st0.rem = i_div.nn;
        n_st0.dd  = i_div.dd;
        n_st0.q   = '0;
    end

    always_ff @(posedge i_clk) begin
        if (en[0]) r_st[0] <= n_st0;
    end

    for (genvar j = 1; j <= KAPPA_W; j++) begin : g_step
        localparam int SH = KAPPA_W - j;
        logic [CMP_W-1:0] sub;
        logic             take;
        t_div_st          n_st;

        always_comb begin
            sub  = CMP_W'(r_st[j-1].dd) << SH;
            take = CMP_W'(r_st[j-1].rem) >= sub;
            n_st = r_st[j-1];
            if (take) begin
                n_st.rem   = NN_W'(CMP_W'(r_st[j-1].rem) - sub);
                n_st.q[SH] = 1'b1;
            end
        end

        always_ff @(posedge i_clk) begin
            if (en[j]) r_st[j] <= n_st;
        end
    end

    always_comb begin
        n_res.row = r_st[KAPPA_W].row;
        n_res.col = r_st[KAPPA_W].col;
        if (r_st[KAPPA_W].dz) begin
            n_res.kappa = '0;
        end else if (r_st[KAPPA_W].neg) begin
            if (r_st[KAPPA_W].ovf || r_st[KAPPA_W].q > KAPPA_MIN) begin
                n_res.kappa = KAPPA_MIN;
            end else begin
                n_res.kappa = KAPPA_W'(0) - r_st[KAPPA_W].q;
            end
        end else begin
            if (r_st[KAPPA_W].ovf || r_st[KAPPA_W].q > KAPPA_MAX) begin
                n_res.kappa = KAPPA_MAX;
            end else begin
                n_res.kappa = r_st[KAPPA_W].q;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en[NST-1]) r_res <= n_res;
    end

endmodule

/* rtl/level_set_curvature_top.sv */
// Top level of the level-set mean curvature pipeline.
//
//  Channel   | Dir | Handshake                    | Contents
//  ----------+-----+------------------------------+----------------------------------------
//  s_axis    | in  | s_axis_tvalid/s_axis_tready  | front point and its 3x3 phi window
//  m_axis    | out | m_axis_tvalid/m_axis_tready  | point with its Q16.16 curvature
//  cfg       | in  | i_cfg_valid/o_cfg_ready      | grid_rows (index 0), grid_cols (index 1)
//
// One point is taken in every cycle unless a stall on m_axis has filled the
// pipeline; each point passes through the five stages of the front end and
// the 32 one-bit steps of the divider, with its overflow check before them
// and its saturating output register after them.
// The synchronous active-low reset empties the pipeline and sets a 256 by 256 grid.
// Every stage moves on when its successor is empty or moving, so a stall on
// m_axis closes up bubbles and keeps s_axis open until the pipeline is full.
module level_set_curvature_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // row, col, phi_center, phi_up, phi_down, phi_left, phi_right,
    // phi_up_left, phi_down_right, phi_down_left, phi_up_right (lowest bits first)
    input  logic [lsc_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // out_row, out_col, kappa (lowest bits first)
    output logic [lsc_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  lsc_pkg::t_cfg_idx                   i_cfg_index,
    input  logic [lsc_pkg::GRID_W-1:0]          i_cfg_data
);
    import lsc_pkg::*;

    logic [GRID_W-1:0] r_grid_rows;
    logic [GRID_W-1:0] r_grid_cols;
    t_grid_cfg         grid;
    t_point            point;
    t_div_in           div_in;
    logic              div_valid;
    logic              div_ready;
    t_result           res;

    // Register writes never wait; writes to unknown indices are dropped.
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_rows <= GRID_RESET;
            r_grid_cols <= GRID_RESET;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_GRID_ROWS: r_grid_rows <= i_cfg_data;
                CFG_GRID_COLS: r_grid_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign grid.rows = r_grid_rows;
    assign grid.cols = r_grid_cols;

    // Unpack the stream word; any padding bits above the fields are ignored.
    always_comb begin
        point.row            = s_axis_tdata[0 +: COORD_W];
        point.col            = s_axis_tdata[COORD_W +: COORD_W];
        point.phi_center     = s_axis_tdata[PHI_LSB + 0 * PHI_W +: PHI_W];
        point.phi_up         = s_axis_tdata[PHI_LSB + 1 * PHI_W +: PHI_W];
        point.phi_down       = s_axis_tdata[PHI_LSB + 2 * PHI_W +: PHI_W];
        point.phi_left       = s_axis_tdata[PHI_LSB + 3 * PHI_W +: PHI_W];
        point.phi_right      = s_axis_tdata[PHI_LSB + 4 * PHI_W +: PHI_W];
        point.phi_up_left    = s_axis_tdata[PHI_LSB + 5 * PHI_W +: PHI_W];
        point.phi_down_right = s_axis_tdata[PHI_LSB + 6 * PHI_W +: PHI_W];
        point.phi_down_left  = s_axis_tdata[PHI_LSB + 7 * PHI_W +: PHI_W];
        point.phi_up_right   = s_axis_tdata[PHI_LSB + 8 * PHI_W +: PHI_W];
    end

    // Differences, products and the divider operands.
    lsc_num u_num (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_grid  (grid),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_point (point),
        .o_valid (div_valid),
        .i_ready (div_ready),
        .o_div   (div_in)
    );

    // Quotient and saturation; its last stage is the output register.
    lsc_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (div_valid),
        .o_ready (div_ready),
        .i_div   (div_in),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_res   (res)
    );

    always_comb begin
        m_axis_tdata                        = '0;
        m_axis_tdata[0 +: COORD_W]          = res.row;
        m_axis_tdata[COORD_W +: COORD_W]    = res.col;
        m_axis_tdata[KAPPA_LSB +: KAPPA_W]  = res.kappa;
    end

endmodule

/* rtl/lsc_checker.sv */
// Port-level checks of the curvature pipeline and their binding to the top level.
module lsc_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            s_axis_tready,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [lsc_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);
    import lsc_pkg::*;

    // A result waiting on the output keeps its valid and its data.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output transfer dropped or changed while stalled");

    // With nothing on the output, no stage can be blocked, so the input is open.
    a_open_when_drained: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled although the output is empty");

    // A point on the first row or column has a border axis and zero curvature.
    a_border_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[0 +: COORD_W] == '0
                          || m_axis_tdata[COORD_W +: COORD_W] == '0)
        |-> m_axis_tdata[KAPPA_LSB +: KAPPA_W] == '0)
        else $error("nonzero curvature on a border point");

    // Reset empties the pipeline.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

endmodule

bind level_set_curvature_top lsc_checker u_lsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* test/level_set_curvature_top_tb.sv */
// Self-checking testbench for the level-set curvature pipeline, with its own curvature predictor.
`timescale 1ns / 100ps

module level_set_curvature_top_tb;

    import lsc_pkg::*;

    // Wide signed working type for the exact curvature arithmetic.
    typedef logic signed [127:0] t_wide;

    localparam int      COORD_MAX    = (1 << COORD_W) - 1;
    localparam int      GRID_MAX     = (1 << GRID_W) - 1;
    localparam int      LIMIT_CYCLES = 400_000;
    // Register indexes that the block must ignore.
    localparam t_cfg_idx CFG_SPARE_A = t_cfg_idx'(2);
    localparam t_cfg_idx CFG_SPARE_B = t_cfg_idx'(3);

    logic                     i_clk         = 1'b0;
    logic                     i_rst_n       = 1'b0;
    logic                     s_axis_tvalid = 1'b0;
    logic                     s_axis_tready;
    logic [IN_TDATA_W-1:0]    s_axis_tdata  = '0;
    logic                     m_axis_tvalid;
    logic                     m_axis_tready = 1'b1;
    logic [OUT_TDATA_W-1:0]   m_axis_tdata;
    logic                     i_cfg_valid   = 1'b0;
    logic                     o_cfg_ready;
    t_cfg_idx                 i_cfg_index   = CFG_GRID_ROWS;
    logic [GRID_W-1:0]        i_cfg_data    = '0;

    // Shadow copy of the grid registers, as the block should hold them.
    int          grid_rows_now = 256;
    int          grid_cols_now = 256;

    // Curvature results still owed by the block, oldest first.
    t_result     kappa_due[$];

    bit          src_gaps    = 1'b0;
    bit          sink_stalls = 1'b0;
    int          error_count;
    int unsigned cycle_count;
    int unsigned points_sent;
    int unsigned results_checked;
    int unsigned zero_kappas;
    int unsigned neg_kappas;
    int unsigned grid_settings;

    level_set_curvature_top u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always #10 i_clk = ~i_clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == LIMIT_CYCLES) begin
            $display("%0t: timeout, %0d results still owed", $time, kappa_due.size());
            $display("level_set_curvature_top_tb NOT OK");
            $finish;
        end
    end

    // Mean curvature of one front point in Q16.16. The first and second
    // differences are kept as integers in units of the phi fraction; the
    // quotient is formed exactly, rounded half away from zero and saturated.
    function automatic logic [KAPPA_W-1:0] curvature_of(input t_point p);
        t_wide              a, xx, b, yy, z, num, den, mag, q;
        bit                 row_in, col_in, neg;
        logic [KAPPA_W-1:0] k;
        row_in = (p.row >= 1) && (int'(p.row) + 1 < grid_rows_now);
        col_in = (p.col >= 1) && (int'(p.col) + 1 < grid_cols_now);
        a  = '0;
        xx = '0;
        b  = '0;
        yy = '0;
        z  = '0;
        k  = '0;
        if (row_in) begin
            a  = t_wide'(p.phi_up) - t_wide'(p.phi_down);
            xx = t_wide'(p.phi_up) - 2 * t_wide'(p.phi_center) + t_wide'(p.phi_down);
        end
        if (col_in) begin
            b  = t_wide'(p.phi_left) - t_wide'(p.phi_right);
            yy = t_wide'(p.phi_left) - 2 * t_wide'(p.phi_center) + t_wide'(p.phi_right);
        end
        // The cross term needs the whole window inside the grid.
        if (row_in && col_in)
            z = t_wide'(p.phi_up_left) + t_wide'(p.phi_down_right)
              - t_wide'(p.phi_down_left) - t_wide'(p.phi_up_right);
        num = 2 * xx * b * b + 2 * yy * a * a - a * b * z;
        den = a * a + b * b;
        // A flat neighbourhood has no gradient, and its curvature is taken as zero.
        if (den != 0) begin
            neg = num < 0;
            mag = (neg ? -num : num) << NORM_SHIFT;
            q   = (2 * mag + den) / (2 * den);
            if (neg)
                k = (q > t_wide'(KAPPA_MIN)) ? KAPPA_MIN : KAPPA_W'(-q);
            else
                k = (q > t_wide'(KAPPA_MAX)) ? KAPPA_MAX : KAPPA_W'(q);
        end
        return k;
    endfunction

    function automatic t_point make_point(input int row, input int col, input int c,
                                          input int up, input int dn, input int lf,
                                          input int rt, input int ul, input int dr,
                                          input int dl, input int ur);
        t_point p;
        p.row            = COORD_W'(row);
        p.col            = COORD_W'(col);
        p.phi_center     = t_phi'(c);
        p.phi_up         = t_phi'(up);
        p.phi_down       = t_phi'(dn);
        p.phi_left       = t_phi'(lf);
        p.phi_right      = t_phi'(rt);
        p.phi_up_left    = t_phi'(ul);
        p.phi_down_right = t_phi'(dr);
        p.phi_down_left  = t_phi'(dl);
        p.phi_up_right   = t_phi'(ur);
        return p;
    endfunction

    function automatic t_phi clamp_phi(input int v);
        if (v > 32767)
            return t_phi'(32767);
        if (v < -32768)
            return t_phi'(-32768);
        return t_phi'(v);
    endfunction

    function automatic t_phi extreme_phi();
        case ($urandom_range(0, 5))
            0:       return t_phi'(-32768);
            1:       return t_phi'(32767);
            2:       return t_phi'(0);
            3:       return t_phi'(-1);
            4:       return t_phi'(1);
            default: return t_phi'($urandom);
        endcase
    endfunction

    // Coordinates lean towards the first and last rows and columns of the grid
    // and the positions just beyond them, where the border rule changes.
    function automatic logic [COORD_W-1:0] pick_coord(input int extent);
        int v;
        case ($urandom_range(0, 7))
            0:       v = 0;
            1:       v = 1;
            2:       v = extent - 2;
            3:       v = extent - 1;
            4:       v = extent;
            5:       v = COORD_MAX;
            default: v = (extent > 1) ? int'($urandom_range(0, extent - 1)) : 0;
        endcase
        if (v < 0 || v > COORD_MAX)
            v = int'($urandom_range(0, COORD_MAX));
        return COORD_W'(v);
    endfunction

    // Half the windows sample a smooth surface with a gradient, some bending and a
    // twist; the rest are random, extreme, flat or flat along one axis.
    function automatic t_point random_point();
        t_point p;
        int     c, gx, gy, hx, hy, tw;
        p.row = pick_coord(grid_rows_now);
        p.col = pick_coord(grid_cols_now);
        c  = int'($urandom_range(0, 65535)) - 32768;
        gx = int'($urandom_range(0, 3000)) - 1500;
        gy = int'($urandom_range(0, 3000)) - 1500;
        hx = int'($urandom_range(0, 800)) - 400;
        hy = int'($urandom_range(0, 800)) - 400;
        tw = int'($urandom_range(0, 600)) - 300;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4: begin
                p.phi_center     = clamp_phi(c);
                p.phi_up         = clamp_phi(c - gx + hx);
                p.phi_down       = clamp_phi(c + gx + hx);
                p.phi_left       = clamp_phi(c - gy + hy);
                p.phi_right      = clamp_phi(c + gy + hy);
                p.phi_up_left    = clamp_phi(c - gx - gy + tw);
                p.phi_down_right = clamp_phi(c + gx + gy + tw);
                p.phi_down_left  = clamp_phi(c + gx - gy - tw);
                p.phi_up_right   = clamp_phi(c - gx + gy - tw);
            end
            5, 6: begin
                p.phi_center     = t_phi'($urandom);
                p.phi_up         = t_phi'($urandom);
                p.phi_down       = t_phi'($urandom);
                p.phi_left       = t_phi'($urandom);
                p.phi_right      = t_phi'($urandom);
                p.phi_up_left    = t_phi'($urandom);
                p.phi_down_right = t_phi'($urandom);
                p.phi_down_left  = t_phi'($urandom);
                p.phi_up_right   = t_phi'($urandom);
            end
            7: begin
                p.phi_center     = extreme_phi();
                p.phi_up         = extreme_phi();
                p.phi_down       = extreme_phi();
                p.phi_left       = extreme_phi();
                p.phi_right      = extreme_phi();
                p.phi_up_left    = extreme_phi();
                p.phi_down_right = extreme_phi();
                p.phi_down_left  = extreme_phi();
                p.phi_up_right   = extreme_phi();
            end
            8: begin
                p = make_point(p.row, p.col, c, c, c, c, c, c, c, c, c);
                if ($urandom_range(0, 1))
                    p.phi_left = t_phi'($urandom);
            end
            default: begin
                p.phi_center     = t_phi'($urandom);
                p.phi_up         = clamp_phi(c);
                p.phi_down       = clamp_phi(c);
                p.phi_left       = t_phi'($urandom);
                p.phi_right      = t_phi'($urandom);
                p.phi_up_left    = t_phi'($urandom);
                p.phi_down_right = t_phi'($urandom);
                p.phi_down_left  = t_phi'($urandom);
                p.phi_up_right   = t_phi'($urandom);
            end
        endcase
        return p;
    endfunction

    // Offers one point on s_axis and books its curvature once the transfer is taken.
    task automatic send_point(input t_point p);
        t_result r;
        if (src_gaps && $urandom_range(0, 5) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {p.phi_up_right, p.phi_down_left, p.phi_down_right, p.phi_up_left,
                          p.phi_right, p.phi_left, p.phi_down, p.phi_up, p.phi_center,
                          p.col, p.row};
        do @(posedge i_clk); while (!s_axis_tready);
        r.row   = p.row;
        r.col   = p.col;
        r.kappa = curvature_of(p);
        kappa_due.push_back(r);
        points_sent++;
    endtask

    // Holds the source back until every booked result has come out.
    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        do @(posedge i_clk); while (kappa_due.size() != 0);
        repeat (4) @(posedge i_clk);
    endtask

    // Rewrites the grid size on an idle pipeline; stray writes to the unused
    // indexes are slipped in between and must leave the grid alone.
    task automatic write_grid(input int rows, input int cols, input bit strays);
        t_cfg_idx          idx_q[$];
        logic [GRID_W-1:0] val_q[$];
        drain_results();
        idx_q.push_back(CFG_GRID_ROWS);
        val_q.push_back(GRID_W'(rows));
        if (strays) begin
            idx_q.push_back(CFG_SPARE_A);
            val_q.push_back(GRID_W'($urandom));
        end
        idx_q.push_back(CFG_GRID_COLS);
        val_q.push_back(GRID_W'(cols));
        if (strays) begin
            idx_q.push_back(CFG_SPARE_B);
            val_q.push_back(GRID_W'($urandom));
        end
        foreach (idx_q[k]) begin
            i_cfg_valid <= 1'b1;
            i_cfg_index <= idx_q[k];
            i_cfg_data  <= val_q[k];
            do @(posedge i_clk); while (!o_cfg_ready);
            case (idx_q[k])
                CFG_GRID_ROWS: grid_rows_now = int'(val_q[k]);
                CFG_GRID_COLS: grid_cols_now = int'(val_q[k]);
                default: ;
            endcase
        end
        i_cfg_valid <= 1'b0;
        grid_settings++;
    endtask

    // Sink side: while stalls are on, m_axis_tready drops now and then for a random burst.
    initial begin
        forever begin
            @(posedge i_clk);
            if (sink_stalls && $urandom_range(0, 5) == 0) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge i_clk);
                m_axis_tready <= 1'b1;
            end
        end
    end

    // Every result transfer is matched against the oldest booked curvature.
    always @(posedge i_clk) begin
        t_result            want;
        logic [COORD_W-1:0] got_row, got_col;
        logic [KAPPA_W-1:0] got_kappa;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got_row   = m_axis_tdata[COORD_W-1:0];
            got_col   = m_axis_tdata[2*COORD_W-1:COORD_W];
            got_kappa = m_axis_tdata[KAPPA_LSB +: KAPPA_W];
            if (kappa_due.size() == 0) begin
                $display("%0t: unexpected result, expected none, got (%0d,%0d) kappa %h",
                         $time, got_row, got_col, got_kappa);
                error_count++;
            end else begin
                want = kappa_due.pop_front();
                results_checked++;
                if (got_kappa == '0)
                    zero_kappas++;
                if (got_kappa[KAPPA_W-1])
                    neg_kappas++;
                if (got_row !== want.row) begin
                    $display("%0t: out_row mismatch, expected %0d, got %0d",
                             $time, want.row, got_row);
                    error_count++;
                end
                if (got_col !== want.col) begin
                    $display("%0t: out_col mismatch, expected %0d, got %0d",
                             $time, want.col, got_col);
                    error_count++;
                end
                if (got_kappa !== want.kappa) begin
                    $display("%0t: kappa mismatch at (%0d,%0d), expected %h, got %h",
                             $time, want.row, want.col, want.kappa, got_kappa);
                    error_count++;
                end
            end
        end
    end

    // Reset grid of 256 by 256: interior windows, each border on its own,
    // corners, flat windows and windows at the extremes of phi.
    task automatic test_reset_grid();
        send_point(make_point(100, 100, 4660, 4660, 4660, 4660, 4660, 4660, 4660, 4660, 4660));
        send_point(make_point(100, 100, 0, 256, -128, 64, -200, 300, -100, 50, 20));
        send_point(make_point(0, 100, 10, 900, -700, 333, -41, 5, 6, 7, 8));
        send_point(make_point(255, 100, 10, 900, -700, 333, -41, 5, 6, 7, 8));
        send_point(make_point(254, 1, -500, 120, 77, -900, 31, 4000, -4000, 17, -3));
        send_point(make_point(100, 0, 10, 900, -700, 333, -41, 5, 6, 7, 8));
        send_point(make_point(100, 255, 10, 900, -700, 333, -41, 5, 6, 7, 8));
        send_point(make_point(0, 0, 10, 900, -700, 333, -41, 5, 6, 7, 8));
        send_point(make_point(COORD_MAX, COORD_MAX, 1, 2, 3, 4, 5, 6, 7, 8, 9));
        send_point(make_point(128, 128, -32768, 32767, -32768, 32767, 32766,
                              32767, 32767, -32768, -32768));
        send_point(make_point(1, 254, 32767, -32768, -32767, -32768, -32768,
                              -32768, -32768, 32767, 32767));
        send_point(make_point(200, 37, 1000, 700, 760, 650, 720, 380, 420, 410, 395));
    endtask

    // Smallest useful grid, where only the centre point is inside, then a grid
    // too small to have an inside at all.
    task automatic test_tiny_grid();
        write_grid(3, 3, 1'b1);
        send_point(make_point(1, 1, -32768, 32767, -32768, -32768, 32767,
                              32767, 32767, -32768, -32768));
        send_point(make_point(0, 1, 0, 300, -300, 128, -64, 1, 2, 3, 4));
        send_point(make_point(2, 1, 0, 300, -300, 128, -64, 1, 2, 3, 4));
        send_point(make_point(1, 2, 0, 300, -300, 128, -64, 1, 2, 3, 4));
        write_grid(0, 2, 1'b0);
        send_point(make_point(1, 1, 0, 300, -300, 128, -64, 1, 2, 3, 4));
    endtask

    // Largest grid, full register range on the columns, at the far edge of the coordinates.
    task automatic test_wide_grid();
        write_grid(4096, GRID_MAX, 1'b1);
        send_point(make_point(4094, COORD_MAX, 77, 1200, -900, 455, 12, -7, 99, 300, -250));
        send_point(make_point(COORD_MAX, 4094, 77, 1200, -900, 455, 12, -7, 99, 300, -250));
        send_point(make_point(4094, 4094, -77, -1200, 900, -455, -12, 7, -99, -300, 250));
    endtask

    // Random windows over a run of grid settings, with idling on either side
    // in most phases and a full hold-off of the source half way through one.
    task automatic test_random_mix();
        for (int ph = 0; ph < 7; ph++) begin
            case (ph)
                0:       write_grid(256, 256, 1'b0);
                1:       write_grid(3, 3, 1'b1);
                2:       write_grid(GRID_MAX, 4096, 1'b0);
                3:       write_grid(17, 33, 1'b1);
                4:       write_grid(0, 300, 1'b0);
                5:       write_grid(4096, 2, 1'b1);
                default: write_grid(int'($urandom_range(0, GRID_MAX)),
                                    int'($urandom_range(0, GRID_MAX)), 1'b1);
            endcase
            src_gaps    = (ph != 2) && (ph != 5);
            sink_stalls = (ph != 2) && (ph != 6);
            for (int n = 0; n < 150; n++) begin
                if (ph == 4 && n == 75)
                    drain_results();
                send_point(random_point());
            end
        end
    endtask

    // Closing stretch at full rate on both sides.
    task automatic test_back_to_back();
        src_gaps    = 1'b0;
        sink_stalls = 1'b0;
        write_grid(int'($urandom_range(3, 300)), int'($urandom_range(3, 300)), 1'b0);
        for (int n = 0; n < 200; n++)
            send_point(random_point());
    endtask

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_grid();
        test_tiny_grid();
        test_wide_grid();
        test_random_mix();
        test_back_to_back();
        drain_results();
        // Anything the block still pushes out after the last booked result is an error.
        repeat (60) @(posedge i_clk);
        $display("Sent %0d front points under %0d grid settings; %0d results checked.",
                 points_sent, grid_settings, results_checked);
        $display("Curvature came out zero for %0d points and negative for %0d.",
                 zero_kappas, neg_kappas);
        if (error_count == 0) begin
            $display("level_set_curvature_top_tb OK");
        end else begin
            $display("%0d mismatches", error_count);
            $display("level_set_curvature_top_tb NOT OK");
        end
        $finish;
    end

endmodule
